>>> rtl/masked_interrupt_controller_assert.svh
// ============================================================================
// Assertion macros for the masked interrupt controller
// Shared concurrent assertion forms, clocked on aclk and disabled in reset.
// ============================================================================
`ifndef MASKED_INTERRUPT_CONTROLLER_ASSERT_SVH
`define MASKED_INTERRUPT_CONTROLLER_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define MIC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// A condition that, when seen, forces a consequence in the next cycle.
`define MIC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mic_pkg.sv
// ============================================================================
// mic_pkg
// Types, constants and helper functions of the masked interrupt controller.
// ============================================================================
package mic_pkg;

    // Default number of bus register words.
    localparam int unsigned NUM_REG_WORDS_DEF = 10;

    // Field widths.
    localparam int unsigned ADDR_W   = 16;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned IRQ_W    = 6;
    localparam int unsigned NUM_IRQ  = 64;
    localparam int unsigned WIDX_W   = ADDR_W - 2;
    localparam int unsigned S_TDATA_W = 56;
    localparam int unsigned S_TUSER_W = 2;
    localparam int unsigned M_TDATA_W = 40;

    // Register word map.
    localparam int unsigned WORD_PEND_LO = 'h0000;
    localparam int unsigned WORD_PEND_HI = 'h0001;
    localparam int unsigned WORD_MASK_LO = 'h0008;
    localparam int unsigned WORD_MASK_HI = 'h0009;

    typedef enum logic [1:0] {
        ACT_READ   = 2'd0,
        ACT_WRITE  = 2'd1,
        ACT_LINE   = 2'd2,
        ACT_ENABLE = 2'd3
    } action_t;

    typedef struct packed {
        logic             found;
        logic [IRQ_W-1:0] idx;
    } scan_hit_t;

    // Maps the two bit-reversed words onto a vector indexed by IRQ number.
    // The low word carries IRQs 63..32 from bit 0 up, the high word 31..0.
    function automatic logic [NUM_IRQ-1:0] irq_vector(
        input logic [DATA_W-1:0] lo_word,
        input logic [DATA_W-1:0] hi_word
    );
        logic [NUM_IRQ-1:0] v;
        for (int i = 0; i < DATA_W; i++) begin
            v[NUM_IRQ-1-i] = lo_word[i];
            v[DATA_W-1-i]  = hi_word[i];
        end
        return v;
    endfunction

    // Highest set bit of a 64-bit vector.
    function automatic scan_hit_t find_highest(input logic [NUM_IRQ-1:0] v);
        scan_hit_t hit;
        hit.found = 1'b0;
        hit.idx   = '0;
        for (int i = 0; i < NUM_IRQ; i++) begin
            if (v[i]) begin
                hit.found = 1'b1;
                hit.idx   = IRQ_W'(i);
            end
        end
        return hit;
    endfunction

endpackage

>>> rtl/masked_interrupt_controller.sv
// ============================================================================
// masked_interrupt_controller
// 64-source interrupt controller with pending and mask words on a bus map.
// ============================================================================
// Usage:
// Every request on the slave stream is one action, chosen by s_axis_tuser:
// a bus read, a bus write, a change of one IRQ line level, or a change of the
// global enable. Every request yields exactly one response on the master
// stream, carrying read data, an access error flag for word indexes at or
// beyond NUM_REG_WORDS, and a delivered IRQ number with its valid flag.
// A request is taken into an input register, fully processed by one pass of
// combinational logic (register update plus a 64-bit priority encoder for
// the delivery scan) and written into the response register. The response
// register is loaded from the input register whenever it is empty or its
// response is being taken. One request can be accepted every cycle while
// the receiver does not stall, so the sustained rate is then one request
// per cycle.
// When the receiver stalls, the response register holds its contents and the
// input register still takes one more request if it is empty; after that
// s_axis_tready drops until the response is taken.
// Reset (aresetn low, synchronous) clears all register words, the delivered
// flags and both pipeline valid bits, and sets the global enable.
// ============================================================================
module masked_interrupt_controller #(
    parameter int unsigned NUM_REG_WORDS = mic_pkg::NUM_REG_WORDS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Request stream.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [15:0] byte_address, [47:16] write_data, [53:48] irq_line,
    // [54] line_level, [55] enable_value
    input  logic [mic_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] action
    input  logic [mic_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    // Response stream.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [31:0] read_data, [32] access_error, [33] irq_deliver, [39:34] irq_number
    output logic [mic_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    localparam int unsigned IDX_W = $clog2(NUM_REG_WORDS);
    localparam int unsigned DW    = mic_pkg::DATA_W;
    localparam int unsigned NI    = mic_pkg::NUM_IRQ;
    localparam int unsigned IW    = mic_pkg::IRQ_W;

    localparam logic [IDX_W-1:0] IDX_PEND_LO = IDX_W'(mic_pkg::WORD_PEND_LO);
    localparam logic [IDX_W-1:0] IDX_PEND_HI = IDX_W'(mic_pkg::WORD_PEND_HI);
    localparam logic [IDX_W-1:0] IDX_MASK_LO = IDX_W'(mic_pkg::WORD_MASK_LO);
    localparam logic [IDX_W-1:0] IDX_MASK_HI = IDX_W'(mic_pkg::WORD_MASK_HI);

    // Input register.
    logic                        in_valid_reg;
    mic_pkg::action_t            in_action_reg;
    logic [mic_pkg::ADDR_W-1:0]  in_addr_reg;
    logic [DW-1:0]               in_data_reg;
    logic [IW-1:0]               in_line_reg;
    logic                        in_level_reg;
    logic                        in_en_reg;

    // Controller state.
    logic [DW-1:0]               words_reg [NUM_REG_WORDS];
    logic [DW-1:0]               words_next [NUM_REG_WORDS];
    logic [NI-1:0]               delivered_reg;
    logic [NI-1:0]               delivered_next;
    logic                        enable_reg;
    logic                        enable_next;

    // Response register.
    logic                        out_valid_reg;
    logic [DW-1:0]               out_rdata_reg;
    logic                        out_err_reg;
    logic                        out_deliver_reg;
    logic [IW-1:0]               out_irq_reg;

    logic                        advance;
    logic                        fire;
    logic [mic_pkg::WIDX_W-1:0]  word_index;
    logic [IDX_W-1:0]            widx;
    logic                        addr_ok;
    logic [IDX_W-1:0]            line_word;
    logic [4:0]                  line_bit;
    logic [NI-1:0]               delivered_mid;
    logic [NI-1:0]               pend_vec;
    logic [NI-1:0]               mask_vec;
    logic [NI-1:0]               eligible;
    logic                        scan_req;
    logic                        deliver;
    mic_pkg::scan_hit_t          hit;
    logic [DW-1:0]               rdata;
    logic                        err;

    // The response register moves whenever it is empty or being taken; the
    // input register refills whenever it is empty or moving on.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    assign word_index = in_addr_reg[mic_pkg::ADDR_W-1:2];
    assign widx       = word_index[IDX_W-1:0];
    assign addr_ok    = word_index < mic_pkg::WIDX_W'(NUM_REG_WORDS);

    // Lines 63..32 live in the low pending word, 31..0 in the high one, both
    // bit reversed, so the bit position is the inverted low five line bits.
    assign line_word = in_line_reg[IW-1] ? IDX_PEND_LO : IDX_PEND_HI;
    assign line_bit  = ~in_line_reg[4:0];

    // Apply the action to the register words and flags.
    always_comb begin
        words_next    = words_reg;
        delivered_mid = delivered_reg;
        enable_next   = enable_reg;
        scan_req      = 1'b0;
        rdata         = '0;
        err           = 1'b0;
        unique case (in_action_reg)
            mic_pkg::ACT_READ: begin
                if (!addr_ok) begin
                    err = 1'b1;
                end else begin
                    rdata = words_reg[widx];
                end
            end
            mic_pkg::ACT_WRITE: begin
                if (!addr_ok) begin
                    err = 1'b1;
                end else begin
                    words_next[widx] = in_data_reg;
                    scan_req = (widx == IDX_MASK_LO) || (widx == IDX_MASK_HI);
                end
            end
            mic_pkg::ACT_LINE: begin
                if (in_level_reg) begin
                    words_next[line_word][line_bit] = 1'b1;
                    scan_req = 1'b1;
                end else begin
                    words_next[line_word][line_bit] = 1'b0;
                    delivered_mid[in_line_reg]      = 1'b0;
                end
            end
            mic_pkg::ACT_ENABLE: begin
                enable_next = in_en_reg;
                scan_req    = in_en_reg;
            end
            default: begin
                err = 1'b0;
            end
        endcase
    end

    // Delivery scan on the updated words: highest pending, unmasked and not
    // yet delivered IRQ wins.
    assign pend_vec = mic_pkg::irq_vector(words_next[IDX_PEND_LO], words_next[IDX_PEND_HI]);
    assign mask_vec = mic_pkg::irq_vector(words_next[IDX_MASK_LO], words_next[IDX_MASK_HI]);
    assign eligible = pend_vec & ~mask_vec & ~delivered_mid;
    assign hit      = mic_pkg::find_highest(eligible);
    assign deliver  = scan_req && enable_next && hit.found;

    always_comb begin
        delivered_next = delivered_mid;
        if (deliver) begin
            delivered_next[hit.idx] = 1'b1;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            in_action_reg <= mic_pkg::action_t'(s_axis_tuser[1:0]);
            in_addr_reg   <= s_axis_tdata[15:0];
            in_data_reg   <= s_axis_tdata[47:16];
            in_line_reg   <= s_axis_tdata[53:48];
            in_level_reg  <= s_axis_tdata[54];
            in_en_reg     <= s_axis_tdata[55];
        end
    end

    // Controller state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REG_WORDS; i++) begin
                words_reg[i] <= '0;
            end
            delivered_reg <= '0;
            enable_reg    <= 1'b1;
        end else if (fire) begin
            words_reg     <= words_next;
            delivered_reg <= delivered_next;
            enable_reg    <= enable_next;
        end
    end

    // Response register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
        if (fire) begin
            out_rdata_reg   <= rdata;
            out_err_reg     <= err;
            out_deliver_reg <= deliver;
            out_irq_reg     <= deliver ? hit.idx : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_irq_reg, out_deliver_reg, out_err_reg, out_rdata_reg};

endmodule

>>> rtl/masked_interrupt_controller_checker.sv
// ============================================================================
// masked_interrupt_controller_checker
// Port-level assertions for the masked interrupt controller, bound to it.
// ============================================================================
`include "masked_interrupt_controller_assert.svh"

module masked_interrupt_controller_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [mic_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    // A stalled response keeps its valid and its contents.
    `MIC_ASSERT_NEXT(a_resp_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "response changed while stalled")

    // With no response waiting, the block always takes a request.
    `MIC_ASSERT_ALWAYS(a_ready_when_free, m_axis_tvalid || s_axis_tready,
        "request refused with the response side empty")

    // The IRQ number is zero unless an interrupt is delivered.
    `MIC_ASSERT_ALWAYS(a_irq_zero, !m_axis_tvalid || m_axis_tdata[33] ||
        (m_axis_tdata[39:34] == '0), "IRQ number set without delivery")

    // A failed bus access never triggers a delivery scan.
    `MIC_ASSERT_ALWAYS(a_err_no_deliver, !m_axis_tvalid || !m_axis_tdata[32] ||
        !m_axis_tdata[33], "delivery reported with an access error")

    // Read data comes only from reads, which neither fail with data nor deliver.
    `MIC_ASSERT_ALWAYS(a_rdata_alone, !m_axis_tvalid || (m_axis_tdata[31:0] == '0) ||
        (!m_axis_tdata[32] && !m_axis_tdata[33]), "read data with error or delivery")

endmodule

bind masked_interrupt_controller masked_interrupt_controller_checker u_checker (.*);
